FILE: hw/rtl/rtlpm_pkg.sv
// ----------------------------------------------------------------------------
// rtlpm_pkg: shared types for the longest-prefix-match route table
// Command and status codes, sequencer states and the per-entry compare flags.
// ----------------------------------------------------------------------------
package rtlpm_pkg;

  // Fixed field widths of the request and result words.
  localparam int ADDR_W    = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int ID_PORT_W = 4;
  localparam int INDEX_W   = 3;

  // Command codes carried by an input word.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_LOOKUP   = 2'd2,
    CMD_RESERVED = 2'd3
  } cmd_e;

  // Status codes carried by a result word.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NO_ROUTE = 2'd2
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_e;

  // Compare flags for the entry currently read from the table.
  typedef struct packed {
    logic hit;   // Entry qualifies for the lookup.
    logic take;  // Entry qualifies and beats the best match so far.
    logic del;   // Entry is valid and belongs to the request's interface.
  } rtlpm_match_t;

endpackage

FILE: hw/rtl/route_table_longest_prefix_top.sv
// ----------------------------------------------------------------------------
// route_table_longest_prefix_top: IPv4 longest-prefix-match route table
// Add, delete-by-interface and lookup commands over a small table of routes.
// ----------------------------------------------------------------------------
// The block handles one word at a time. Route fields sit in a synchronous
// memory and the valid bits in flip-flops, so reset empties the table at once
// with no clearing pass. A sequencer walks the entries one per cycle: a lookup
// or a delete reads every entry through the memory's single read port, an add
// checks only the valid bits and stops at the first free slot, and command code
// three skips the scan. A result that cannot leave the output register holds the
// sequencer in its last step. The result sits in an output register, so a new
// word is taken while the previous result still waits.
module route_table_longest_prefix_top #(
  parameter int TABLE_ENTRIES  = 8,
  parameter int INTERFACE_BITS = 4,
  parameter int NAMESPACE_BITS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rtlpm_pkg::CMD_W-1:0]     command_i,
  input  logic [rtlpm_pkg::ADDR_W-1:0]    address_i,
  input  logic [rtlpm_pkg::ADDR_W-1:0]    mask_i,
  input  logic [rtlpm_pkg::ADDR_W-1:0]    next_hop_i,
  input  logic [rtlpm_pkg::ID_PORT_W-1:0] interface_id_i,
  input  logic                           interface_any_i,
  input  logic [rtlpm_pkg::ID_PORT_W-1:0] namespace_id_i,
  input  logic                           namespace_any_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rtlpm_pkg::STATUS_W-1:0]  status_o,
  output logic [rtlpm_pkg::ADDR_W-1:0]    route_next_hop_o,
  output logic [rtlpm_pkg::ID_PORT_W-1:0] route_interface_o,
  output logic [rtlpm_pkg::INDEX_W-1:0]   entry_index_o
);
  import rtlpm_pkg::*;

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int EntW = 3 * ADDR_W + INTERFACE_BITS + NAMESPACE_BITS;
  localparam logic [CntW-1:0] EndCnt = CntW'(TABLE_ENTRIES);

  // Sequencer and table control state.
  state_e                    state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]           chk_idx_q, chk_idx_d;
  logic [TABLE_ENTRIES-1:0]  valid_q, valid_d;
  logic                      best_found_q, best_found_d;
  logic [IdxW-1:0]           best_idx_q, best_idx_d;
  logic [ADDR_W-1:0]         best_mask_q, best_mask_d;
  logic [ADDR_W-1:0]         best_hop_q, best_hop_d;
  logic [INTERFACE_BITS-1:0] best_ifc_q, best_ifc_d;

  // Latched request word.
  cmd_e                      cmd_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [ADDR_W-1:0]         mask_q;
  logic [ADDR_W-1:0]         hop_q;
  logic [INTERFACE_BITS-1:0] ifc_q;
  logic                      ifc_any_q;
  logic [NAMESPACE_BITS-1:0] ns_q;
  logic                      ns_any_q;

  // Output register.
  logic                      out_valid_q;
  status_e                   status_q, res_status;
  logic [ADDR_W-1:0]         hop_out_q, res_hop;
  logic [ID_PORT_W-1:0]      ifc_out_q, res_ifc;
  logic [INDEX_W-1:0]        idx_out_q, res_idx;

  // Memory and compare signals.
  logic                      accept;
  logic                      load_out;
  logic [IdxW-1:0]           cnt_idx;
  logic                      ram_we;
  logic                      ram_re;
  logic [EntW-1:0]           ram_wdata;
  logic [EntW-1:0]           ram_rdata;
  logic [ADDR_W-1:0]         ent_net;
  logic [ADDR_W-1:0]         ent_mask;
  logic [ADDR_W-1:0]         ent_hop;
  logic [INTERFACE_BITS-1:0] ent_ifc;
  logic [NAMESPACE_BITS-1:0] ent_ns;
  rtlpm_match_t              match;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_idx    = cnt_q[IdxW-1:0];

  // Route field storage.
  assign ram_wdata = {addr_q, mask_q, hop_q, ifc_q, ns_q};
  assign {ent_net, ent_mask, ent_hop, ent_ifc, ent_ns} = ram_rdata;

  rtlpm_entry_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (EntW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_idx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_idx),
    .rdata_o (ram_rdata)
  );

  // Compare of the entry read in the previous cycle.
  rtlpm_match #(
    .IF_W (INTERFACE_BITS),
    .NS_W (NAMESPACE_BITS)
  ) u_match (
    .entry_valid_i   (valid_q[chk_idx_q]),
    .entry_network_i (ent_net),
    .entry_mask_i    (ent_mask),
    .entry_ifc_i     (ent_ifc),
    .entry_ns_i      (ent_ns),
    .req_addr_i      (addr_q),
    .req_ifc_i       (ifc_q),
    .req_ifc_any_i   (ifc_any_q),
    .req_ns_i        (ns_q),
    .req_ns_any_i    (ns_any_q),
    .best_found_i    (best_found_q),
    .best_mask_i     (best_mask_q),
    .match_o         (match)
  );

  // Request capture; identifiers are cut or extended to their stored widths.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_e'(command_i);
      addr_q    <= address_i;
      mask_q    <= mask_i;
      hop_q     <= next_hop_i;
      ifc_q     <= INTERFACE_BITS'(interface_id_i);
      ifc_any_q <= interface_any_i;
      ns_q      <= NAMESPACE_BITS'(namespace_id_i);
      ns_any_q  <= namespace_any_i;
    end
  end

  // Sequencer: walks the table one entry per cycle.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    valid_d      = valid_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_mask_d  = best_mask_q;
    best_hop_d   = best_hop_q;
    best_ifc_d   = best_ifc_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    load_out     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d        = '0;
          best_found_d = 1'b0;
          state_d      = (command_i == CMD_RESERVED) ? S_RESULT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmd_q == CMD_ADD) begin
          // Add needs only the valid bits: stop at the first free slot.
          if (cnt_q == EndCnt) begin
            state_d = S_RESULT;
          end else if (!valid_q[cnt_idx]) begin
            ram_we           = 1'b1;
            valid_d[cnt_idx] = 1'b1;
            best_found_d     = 1'b1;
            best_idx_d       = cnt_idx;
            state_d          = S_RESULT;
          end else begin
            cnt_d = CntW'(cnt_q + 1'b1);
          end
        end else begin
          // Lookup and delete read every entry; the last one is checked
          // in the cycle that leaves the scan.
          if (cnt_q != EndCnt) begin
            ram_re    = 1'b1;
            chk_vld_d = 1'b1;
            chk_idx_d = cnt_idx;
            cnt_d     = CntW'(cnt_q + 1'b1);
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Act on the entry that came out of the memory this cycle.
    if (chk_vld_q) begin
      if ((cmd_q == CMD_DELETE) && match.del) begin
        valid_d[chk_idx_q] = 1'b0;
      end
      if ((cmd_q == CMD_LOOKUP) && match.take) begin
        best_found_d = 1'b1;
        best_idx_d   = chk_idx_q;
        best_mask_d  = ent_mask;
        best_hop_d   = ent_hop;
        best_ifc_d   = ent_ifc;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      chk_vld_q    <= 1'b0;
      chk_idx_q    <= '0;
      valid_q      <= '0;
      best_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      chk_vld_q    <= chk_vld_d;
      chk_idx_q    <= chk_idx_d;
      valid_q      <= valid_d;
      best_found_q <= best_found_d;
    end
  end

  // Best-match payload registers.
  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_mask_q <= best_mask_d;
    best_hop_q  <= best_hop_d;
    best_ifc_q  <= best_ifc_d;
  end

  // Result word for the finished command.
  always_comb begin
    res_status = STATUS_OK;
    res_hop    = '0;
    res_ifc    = '0;
    res_idx    = '0;
    case (cmd_q)
      CMD_ADD: begin
        if (best_found_q) begin
          res_idx = INDEX_W'(best_idx_q);
        end else begin
          res_status = STATUS_FULL;
        end
      end
      CMD_LOOKUP: begin
        if (best_found_q) begin
          res_hop = best_hop_q;
          res_ifc = ID_PORT_W'(best_ifc_q);
          res_idx = INDEX_W'(best_idx_q);
        end else begin
          res_status = STATUS_NO_ROUTE;
        end
      end
      default: begin
        res_status = STATUS_OK;
      end
    endcase
  end

  // Output register: holds the word until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q  <= res_status;
      hop_out_q <= res_hop;
      ifc_out_q <= res_ifc;
      idx_out_q <= res_idx;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign route_next_hop_o  = hop_out_q;
  assign route_interface_o = ifc_out_q;
  assign entry_index_o     = idx_out_q;

  // A memory read is checked only while the scan is running.
  a_chk_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (state_q == S_SCAN))
    else $error("entry check outside of a scan");

  // Only an add may mark new entries valid.
  a_no_spurious_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && (cmd_q != CMD_ADD)) |=>
      ($countones(valid_q) <= $countones($past(valid_q))))
    else $error("valid entry appeared outside of an add");

  // An add reports a full table only when every slot is taken.
  a_full_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RESULT) && (cmd_q == CMD_ADD) && !best_found_q) |-> (&valid_q))
    else $error("table full reported with a free slot");

endmodule

FILE: hw/rtl/rtlpm_entry_ram.sv
// ----------------------------------------------------------------------------
// rtlpm_entry_ram: route entry storage
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module rtlpm_entry_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/rtlpm_match.sv
// ----------------------------------------------------------------------------
// rtlpm_match: per-entry route compare
// Checks one stored entry against a lookup or delete request and against the
// best match found so far.
// ----------------------------------------------------------------------------
module rtlpm_match #(
  parameter int IF_W = 4,
  parameter int NS_W = 4
) (
  input  logic                        entry_valid_i,
  input  logic [rtlpm_pkg::ADDR_W-1:0] entry_network_i,
  input  logic [rtlpm_pkg::ADDR_W-1:0] entry_mask_i,
  input  logic [IF_W-1:0]             entry_ifc_i,
  input  logic [NS_W-1:0]             entry_ns_i,
  input  logic [rtlpm_pkg::ADDR_W-1:0] req_addr_i,
  input  logic [IF_W-1:0]             req_ifc_i,
  input  logic                        req_ifc_any_i,
  input  logic [NS_W-1:0]             req_ns_i,
  input  logic                        req_ns_any_i,
  input  logic                        best_found_i,
  input  logic [rtlpm_pkg::ADDR_W-1:0] best_mask_i,
  output rtlpm_pkg::rtlpm_match_t     match_o
);
  import rtlpm_pkg::*;

  logic ifc_eq;
  logic ns_eq;
  logic net_eq;

  assign ifc_eq = (entry_ifc_i == req_ifc_i);
  assign ns_eq  = (entry_ns_i == req_ns_i);
  assign net_eq = ((req_addr_i & entry_mask_i) == entry_network_i);

  // The numerically larger mask wins; on equal masks the earlier entry stays.
  always_comb begin
    match_o.hit  = entry_valid_i && net_eq && (req_ifc_any_i || ifc_eq) &&
                   (req_ns_any_i || ns_eq);
    match_o.take = match_o.hit && (!best_found_i || (entry_mask_i > best_mask_i));
    match_o.del  = entry_valid_i && ifc_eq;
  end

endmodule

FILE: test/route_table_checker.sv
// ----------------------------------------------------------------------------
// route_table_checker: scoreboard for the longest-prefix-match route table
// Watches both channels, keeps its own copy of the route table, works out the
// result word of every accepted command and compares it with the block's.
// ----------------------------------------------------------------------------
module route_table_checker #(
  parameter int TABLE_ENTRIES  = 8,
  parameter int INTERFACE_BITS = 4,
  parameter int NAMESPACE_BITS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [rtlpm_pkg::CMD_W-1:0]     command_i,
  input  logic [rtlpm_pkg::ADDR_W-1:0]    address_i,
  input  logic [rtlpm_pkg::ADDR_W-1:0]    mask_i,
  input  logic [rtlpm_pkg::ADDR_W-1:0]    next_hop_i,
  input  logic [rtlpm_pkg::ID_PORT_W-1:0] interface_id_i,
  input  logic                            interface_any_i,
  input  logic [rtlpm_pkg::ID_PORT_W-1:0] namespace_id_i,
  input  logic                            namespace_any_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [rtlpm_pkg::STATUS_W-1:0]  status_i,
  input  logic [rtlpm_pkg::ADDR_W-1:0]    route_next_hop_i,
  input  logic [rtlpm_pkg::ID_PORT_W-1:0] route_interface_i,
  input  logic [rtlpm_pkg::INDEX_W-1:0]   entry_index_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              compared_o,
  output int                              lookup_hits_o,
  output int                              lookup_misses_o,
  output int                              adds_refused_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtlpm_pkg::*;

  // One slot of the shadow route table.
  typedef struct {
    logic                      valid;
    logic [ADDR_W-1:0]         network;
    logic [ADDR_W-1:0]         netmask;
    logic [ADDR_W-1:0]         gateway;
    logic [INTERFACE_BITS-1:0] ifc;
    logic [NAMESPACE_BITS-1:0] ns;
  } route_slot_t;

  // Expected result word, tagged with the command that caused it.
  typedef struct {
    cmd_e                 kind;
    status_e              status;
    logic [ADDR_W-1:0]    next_hop;
    logic [ID_PORT_W-1:0] ifc;
    logic [INDEX_W-1:0]   index;
  } route_result_t;

  route_slot_t   routes [TABLE_ENTRIES];
  route_result_t route_results_q [$];

  // Apply one command to the shadow table and return the result it causes.
  function automatic route_result_t resolve_command(
    input cmd_e                 cmd,
    input logic [ADDR_W-1:0]    addr,
    input logic [ADDR_W-1:0]    msk,
    input logic [ADDR_W-1:0]    hop,
    input logic [ID_PORT_W-1:0] ifc_in,
    input logic                 if_any,
    input logic [ID_PORT_W-1:0] ns_in,
    input logic                 ns_any
  );
    logic [INTERFACE_BITS-1:0] ifc;
    logic [NAMESPACE_BITS-1:0] ns;
    route_result_t             res;
    bit                        found;
    int                        best;
    // Identifiers wider than the table's fields lose their upper bits.
    ifc          = INTERFACE_BITS'(ifc_in);
    ns           = NAMESPACE_BITS'(ns_in);
    res.kind     = cmd;
    res.status   = STATUS_OK;
    res.next_hop = '0;
    res.ifc      = '0;
    res.index    = '0;
    found        = 1'b0;
    best         = 0;
    case (cmd)
      // Add takes the lowest free slot; a full table stays untouched.
      CMD_ADD: begin
        res.status = STATUS_FULL;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!found && !routes[i].valid) begin
            routes[i].valid   = 1'b1;
            routes[i].network = addr;
            routes[i].netmask = msk;
            routes[i].gateway = hop;
            routes[i].ifc     = ifc;
            routes[i].ns      = ns;
            found             = 1'b1;
            res.status        = STATUS_OK;
            res.index         = INDEX_W'(i);
          end
        end
      end
      // Delete drops every live route of the interface.
      CMD_DELETE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (routes[i].valid && routes[i].ifc == ifc) routes[i].valid = 1'b0;
        end
      end
      // Lookup keeps the numerically largest mask; the first slot wins a tie.
      CMD_LOOKUP: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (routes[i].valid && (addr & routes[i].netmask) == routes[i].network &&
              (if_any || routes[i].ifc == ifc) && (ns_any || routes[i].ns == ns)) begin
            if (!found || routes[i].netmask > routes[best].netmask) begin
              found = 1'b1;
              best  = i;
            end
          end
        end
        if (found) begin
          res.next_hop = routes[best].gateway;
          res.ifc      = ID_PORT_W'(routes[best].ifc);
          res.index    = INDEX_W'(best);
        end else begin
          res.status = STATUS_NO_ROUTE;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Compare each result word with the oldest expectation, then record new commands.
  always @(posedge clk_i or negedge rst_ni) begin
    route_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) routes[i].valid = 1'b0;
      route_results_q.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      compared_o      = 0;
      lookup_hits_o   = 0;
      lookup_misses_o = 0;
      adds_refused_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        compared_o++;
        if (route_results_q.size() == 0) begin
          $error("result word with no command outstanding: status %0d index %0d",
                 status_i, entry_index_i);
          fail_count_o++;
        end else begin
          want = route_results_q.pop_front();
          if (want.kind == CMD_LOOKUP && want.status == STATUS_OK) lookup_hits_o++;
          if (want.status == STATUS_NO_ROUTE) lookup_misses_o++;
          if (want.status == STATUS_FULL) adds_refused_o++;
          if (status_i !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (route_next_hop_i !== want.next_hop) begin
            $error("route_next_hop mismatch: expected %h, got %h",
                   want.next_hop, route_next_hop_i);
            fail_count_o++;
          end
          if (route_interface_i !== want.ifc) begin
            $error("route_interface mismatch: expected %0d, got %0d",
                   want.ifc, route_interface_i);
            fail_count_o++;
          end
          if (entry_index_i !== want.index) begin
            $error("entry_index mismatch: expected %0d, got %0d",
                   want.index, entry_index_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        route_results_q.push_back(resolve_command(cmd_e'(command_i), address_i, mask_i,
                                                  next_hop_i, interface_id_i,
                                                  interface_any_i, namespace_id_i,
                                                  namespace_any_i));
      end
      pending_o = route_results_q.size();
    end
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the longest-prefix-match route table
// Drives directed and random words of all four command codes with random gaps and
// a long output stall; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES  = 8;
  localparam int INTERFACE_BITS = 4;
  localparam int NAMESPACE_BITS = 4;
  localparam int RANDOM_WORDS   = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int POOL_SIZE      = 8;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [rtlpm_pkg::CMD_W-1:0]     command       = '0;
  logic [rtlpm_pkg::ADDR_W-1:0]    address       = '0;
  logic [rtlpm_pkg::ADDR_W-1:0]    mask          = '0;
  logic [rtlpm_pkg::ADDR_W-1:0]    next_hop      = '0;
  logic [rtlpm_pkg::ID_PORT_W-1:0] interface_id  = '0;
  logic                            interface_any = 1'b0;
  logic [rtlpm_pkg::ID_PORT_W-1:0] namespace_id  = '0;
  logic                            namespace_any = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [rtlpm_pkg::STATUS_W-1:0]  status;
  logic [rtlpm_pkg::ADDR_W-1:0]    route_next_hop;
  logic [rtlpm_pkg::ID_PORT_W-1:0] route_interface;
  logic [rtlpm_pkg::INDEX_W-1:0]   entry_index;

  int fails, pending, compared, lookup_hits, lookup_misses, adds_refused;
  int cycles = 0;
  int cmd_count [4];
  bit gaps_on    = 1'b1;
  bit hold_armed = 1'b0;

  // Recently added routes, used to aim lookups at live prefixes.
  bit [31:0] pool_net  [POOL_SIZE];
  bit [31:0] pool_mask [POOL_SIZE];
  bit [3:0]  pool_if   [POOL_SIZE];
  bit [3:0]  pool_ns   [POOL_SIZE];
  int        pool_wr = 0;

  route_table_longest_prefix_top #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .INTERFACE_BITS (INTERFACE_BITS),
    .NAMESPACE_BITS (NAMESPACE_BITS)
  ) i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .command_i         (command),
    .address_i         (address),
    .mask_i            (mask),
    .next_hop_i        (next_hop),
    .interface_id_i    (interface_id),
    .interface_any_i   (interface_any),
    .namespace_id_i    (namespace_id),
    .namespace_any_i   (namespace_any),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status),
    .route_next_hop_o  (route_next_hop),
    .route_interface_o (route_interface),
    .entry_index_o     (entry_index)
  );

  route_table_checker #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .INTERFACE_BITS (INTERFACE_BITS),
    .NAMESPACE_BITS (NAMESPACE_BITS)
  ) i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .command_i         (command),
    .address_i         (address),
    .mask_i            (mask),
    .next_hop_i        (next_hop),
    .interface_id_i    (interface_id),
    .interface_any_i   (interface_any),
    .namespace_id_i    (namespace_id),
    .namespace_any_i   (namespace_any),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .status_i          (status),
    .route_next_hop_i  (route_next_hop),
    .route_interface_i (route_interface),
    .entry_index_i     (entry_index),
    .fail_count_o      (fails),
    .pending_o         (pending),
    .compared_o        (compared),
    .lookup_hits_o     (lookup_hits),
    .lookup_misses_o   (lookup_misses),
    .adds_refused_o    (adds_refused)
  );

  // Clock generation.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle counter with a watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Result sink: random back-pressure plus one long hold-off.
  initial begin : result_sink
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(0, 99) < 12);
      end
    end
  end

  // Offer one word, with an optional random gap first, and wait until it is taken.
  task automatic send_word(input rtlpm_pkg::cmd_e cmd, input logic [31:0] addr,
                           input logic [31:0] msk, input logic [31:0] hop,
                           input logic [3:0] ifc, input logic if_any,
                           input logic [3:0] ns, input logic ns_any);
    while (gaps_on && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    address       <= addr;
    mask          <= msk;
    next_hop      <= hop;
    interface_id  <= ifc;
    interface_any <= if_any;
    namespace_id  <= ns;
    namespace_any <= ns_any;
    cmd_count[int'(cmd)]++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic add_route(input logic [31:0] net, input logic [31:0] msk,
                           input logic [31:0] hop, input logic [3:0] ifc,
                           input logic [3:0] ns);
    send_word(rtlpm_pkg::CMD_ADD, net, msk, hop, ifc, 1'($urandom_range(0, 1)), ns,
              1'($urandom_range(0, 1)));
  endtask

  task automatic lookup_route(input logic [31:0] dest, input logic [3:0] ifc,
                              input logic if_any, input logic [3:0] ns,
                              input logic ns_any);
    send_word(rtlpm_pkg::CMD_LOOKUP, dest, $urandom(), $urandom(), ifc, if_any, ns, ns_any);
  endtask

  task automatic delete_routes(input logic [3:0] ifc);
    send_word(rtlpm_pkg::CMD_DELETE, $urandom(), $urandom(), $urandom(), ifc,
              1'($urandom_range(0, 1)), 4'($urandom()), 1'($urandom_range(0, 1)));
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int              r, len, p;
    logic [31:0]     a, m, h;
    logic [3:0]      fi, fn;
    logic            fa, na;
    rtlpm_pkg::cmd_e c;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: lookup misses, delete and the unused code do nothing.
    lookup_route(32'hC0A8_0105, 4'd0, 1'b1, 4'd0, 1'b1);
    delete_routes(4'd3);
    send_word(rtlpm_pkg::CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              4'hF, 1'b1, 4'hF, 1'b1);

    // Fill all eight slots: default route, nested prefixes, a host route,
    // a duplicate prefix, an all-ones route, a non-contiguous mask and a
    // network with bits outside its mask.
    add_route(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'd0,  4'd0);
    add_route(32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_0001, 4'd1,  4'd0);
    add_route(32'hC0A8_0100, 32'hFFFF_FF00, 32'hFFFF_FFFF, 4'd15, 4'd15);
    add_route(32'hC0A8_0105, 32'hFFFF_FFFF, 32'h0A00_0001, 4'd2,  4'd1);
    add_route(32'hC0A8_0100, 32'hFFFF_FF00, 32'h1234_5678, 4'd15, 4'd15);
    add_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 4'd3,  4'd2);
    add_route(32'h0505_0505, 32'h0F0F_0F0F, 32'h5555_5555, 4'd4,  4'd3);
    add_route(32'h1234_5678, 32'hFF00_0000, 32'h0000_0001, 4'd5,  4'd4);
    // Table full.
    add_route(32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'd6,  4'd5);

    // Longest prefix, tie on equal masks, filters and the default route.
    lookup_route(32'hC0A8_0105, 4'd0,  1'b1, 4'd0,  1'b1);
    lookup_route(32'hC0A8_0107, 4'd0,  1'b1, 4'd0,  1'b1);
    lookup_route(32'hC0A8_0107, 4'd15, 1'b0, 4'd0,  1'b1);
    lookup_route(32'hC0A8_0105, 4'd1,  1'b0, 4'd0,  1'b1);
    lookup_route(32'hC0A8_0105, 4'd1,  1'b0, 4'd1,  1'b0);
    lookup_route(32'hFFFF_FFFF, 4'd0,  1'b1, 4'd0,  1'b1);
    lookup_route(32'h25A5_C5E5, 4'd0,  1'b1, 4'd0,  1'b1);
    lookup_route(32'h1234_5678, 4'd0,  1'b1, 4'd0,  1'b1);
    lookup_route(32'hC0A8_01FF, 4'd15, 1'b0, 4'd15, 1'b0);

    // Delete frees two slots; the next add reuses the lower one.
    delete_routes(4'd15);
    lookup_route(32'hC0A8_0107, 4'd0, 1'b1, 4'd0, 1'b1);
    add_route(32'hAC10_0000, 32'hFFF0_0000, 32'h0000_0000, 4'd7, 4'd6);
    delete_routes(4'd0);
    lookup_route(32'h0102_0304, 4'd0, 1'b1, 4'd0, 1'b1);

    // Random part: mostly lookups aimed at recently added prefixes.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 50) hold_armed = 1'b1;
      gaps_on = !(n >= 800 && n < 1100);
      r = $urandom_range(0, 99);
      if (r < 28) c = rtlpm_pkg::CMD_ADD;
      else if (r < 38) c = rtlpm_pkg::CMD_DELETE;
      else if (r < 96) c = rtlpm_pkg::CMD_LOOKUP;
      else c = rtlpm_pkg::CMD_RESERVED;
      len = $urandom_range(0, 32);
      if ($urandom_range(0, 4) == 0) m = $urandom();
      else if (len == 0) m = 32'h0;
      else m = ~32'h0 << (32 - len);
      a  = $urandom();
      h  = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
      fi = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 3));
      fn = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 2));
      fa = 1'($urandom_range(0, 1));
      na = 1'($urandom_range(0, 1));
      if (c == rtlpm_pkg::CMD_ADD) begin
        // Most routes keep their network inside the mask.
        if ($urandom_range(0, 6) != 0) a = a & m;
        pool_net[pool_wr]  = a;
        pool_mask[pool_wr] = m;
        pool_if[pool_wr]   = fi;
        pool_ns[pool_wr]   = fn;
        pool_wr            = (pool_wr + 1) % POOL_SIZE;
      end else if (c == rtlpm_pkg::CMD_LOOKUP && $urandom_range(0, 3) != 0) begin
        p = $urandom_range(0, POOL_SIZE - 1);
        a = (pool_net[p] & pool_mask[p]) | (a & ~pool_mask[p]);
        if (!fa && $urandom_range(0, 4) != 0) fi = pool_if[p];
        if (!na && $urandom_range(0, 4) != 0) fn = pool_ns[p];
      end
      send_word(c, a, m, h, fi, fa, fn, na);
    end
    in_valid <= 1'b0;
    gaps_on = 1'b1;

    // Drain the outstanding results, then watch for stray words.
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d add, %0d delete, %0d lookup and %0d unused-code words.",
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
    $display("%0d results compared: %0d lookup hits, %0d misses, %0d adds refused.",
             compared, lookup_hits, lookup_misses, adds_refused);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rtlpm_pkg.sv
hw/rtl/rtlpm_entry_ram.sv
hw/rtl/rtlpm_match.sv
hw/rtl/route_table_longest_prefix_top.sv
test/route_table_checker.sv
test/tb.sv
